@@ rtl/csx_pkg.sv @@
// Shared types and constants for the categorical sampler with xorshift64* coin.
// Used by csx_coin_gen, csx_scan and categorical_sampler_xorshift.
package csx_pkg;

  // Field widths of the streaming channels.
  localparam int PROB_W      = 25;
  localparam int IDX_OUT_W   = 17;
  localparam int SUM_W       = 42;
  localparam int COIN_W      = 24;
  localparam int STATE_W     = 64;
  localparam int HALF_W      = 32;

  // Default vector length limit handed to the top level.
  localparam int MAX_VOCAB_DEF = 131072;

  // Generator constants.
  localparam logic [STATE_W-1:0] XS_MULT    = 64'h2545_F491_4F6C_DD1D;
  localparam logic [STATE_W-1:0] SEED_RESET = 64'd1337;
  localparam int XS_SHIFT_A = 12;
  localparam int XS_SHIFT_B = 25;
  localparam int XS_SHIFT_C = 27;

  // Prefetched coin queue.
  localparam int COIN_Q_DEPTH = 4;
  localparam int COIN_Q_PTR_W = $clog2(COIN_Q_DEPTH);
  localparam int COIN_Q_CNT_W = $clog2(COIN_Q_DEPTH + 1);

  // Configuration register map (byte address bit 3 selects the 64-bit slot).
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam logic REG_SEED = 1'b0;

  // Coin channel from the generator to the scanner.
  typedef struct packed {
    logic              avail;
    logic [COIN_W-1:0] coin;
  } coin_t;

  // One xorshift64 state advance.
  function automatic logic [STATE_W-1:0] xs_advance(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] t;
    t = s ^ (s >> XS_SHIFT_A);
    t = t ^ (t << XS_SHIFT_B);
    t = t ^ (t >> XS_SHIFT_C);
    return t;
  endfunction

endpackage

@@ rtl/csx_coin_gen.sv @@
// Coin generator: xorshift64* state, two-stage split multiply, small coin queue.
// Depends on csx_pkg.
module csx_coin_gen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [csx_pkg::STATE_W-1:0]  load_value,
  input  logic                         pop,
  output csx_pkg::coin_t               coin_o
);
  import csx_pkg::*;

  logic [STATE_W-1:0]      state_r, state_nxt;
  logic                    v0_r, v0_nxt;
  logic                    v1_r, v1_nxt;
  logic [2*HALF_W-1:0]     pp_lo_r, pp_lo_nxt;
  logic [HALF_W-1:0]       pp_a_r, pp_a_nxt;
  logic [HALF_W-1:0]       pp_b_r, pp_b_nxt;
  logic [COIN_W-1:0]       coin_q_r [COIN_Q_DEPTH];
  logic [COIN_Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [COIN_Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [COIN_Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COIN_Q_CNT_W-1:0] used;
  logic                    issue;
  logic                    push;
  logic [HALF_W-1:0]       out_word;
  logic [HALF_W-1:0]       s_lo, s_hi, m_lo, m_hi;

  // Credits: queued coins plus coins still in the multiply pipeline.
  assign used  = cnt_r + COIN_Q_CNT_W'(v0_r) + COIN_Q_CNT_W'(v1_r);
  assign issue = !load && (used < COIN_Q_CNT_W'(COIN_Q_DEPTH));
  assign push  = !load && v1_r;

  assign s_lo = state_r[HALF_W-1:0];
  assign s_hi = state_r[STATE_W-1:HALF_W];
  assign m_lo = XS_MULT[HALF_W-1:0];
  assign m_hi = XS_MULT[STATE_W-1:HALF_W];

  // Bits 63:32 of the truncated 64-bit product, rebuilt from partial products.
  assign out_word = pp_lo_r[2*HALF_W-1:HALF_W] + pp_a_r + pp_b_r;

  // Generator state and multiply pipeline.
  always_comb begin
    state_nxt  = state_r;
    v0_nxt     = 1'b0;
    v1_nxt     = 1'b0;
    pp_lo_nxt  = 64'(s_lo) * 64'(m_lo);
    pp_a_nxt   = s_hi * m_lo;
    pp_b_nxt   = s_lo * m_hi;
    if (load) begin
      state_nxt = load_value;
    end else begin
      if (issue) begin
        state_nxt = xs_advance(state_r);
      end
      v0_nxt = issue;
      v1_nxt = v0_r;
    end
  end

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (load) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      cnt_nxt    = '0;
    end else begin
      if (push) begin
        wr_ptr_nxt = wr_ptr_r + COIN_Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_nxt = rd_ptr_r + COIN_Q_PTR_W'(1);
      end
      cnt_nxt = cnt_r + COIN_Q_CNT_W'(push) - COIN_Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SEED_RESET;
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      v0_r     <= v0_nxt;
      v1_r     <= v1_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    pp_lo_r <= pp_lo_nxt;
    pp_a_r  <= pp_a_nxt;
    pp_b_r  <= pp_b_nxt;
    if (push) begin
      coin_q_r[wr_ptr_r] <= out_word[HALF_W-1:HALF_W-COIN_W];
    end
  end

  assign coin_o.avail = (cnt_r != '0);
  assign coin_o.coin  = coin_q_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used <= COIN_Q_CNT_W'(COIN_Q_DEPTH))
    else $error("coin queue credits exceeded");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("coin taken from empty queue");
  a_load_flush: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r == '0) && !v0_r && !v1_r)
    else $error("seed load did not flush prefetched coins");
`endif

endmodule

@@ rtl/csx_scan.sv @@
// Inverse-CDF scan: running sum, coin compare, hit tracking and result register.
// Depends on csx_pkg.
module csx_scan #(
  parameter int MAX_VOCAB = csx_pkg::MAX_VOCAB_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csx_pkg::PROB_W-1:0]    in_prob,
  input  logic                          in_last,
  input  csx_pkg::coin_t                coin_i,
  output logic                          coin_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csx_pkg::IDX_OUT_W-1:0] out_token_index,
  output logic                          out_fallback
);
  import csx_pkg::*;

  localparam int CNT_W = $clog2(MAX_VOCAB);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(MAX_VOCAB - 1);

  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [COIN_W-1:0]    coin_r, coin_nxt;
  logic                 hit_r, hit_nxt;
  logic [CNT_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0] tok_r, tok_nxt;
  logic                 fb_r, fb_nxt;
  logic                 first;
  logic                 acc;
  logic [COIN_W-1:0]    coin_cur;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_sat;
  logic                 hit_now;

  // A vector may start only when a prefetched coin is waiting; a last
  // element needs the result register free.
  assign first    = (pos_r == '0);
  assign in_ready = (!first || coin_i.avail) && (!out_valid_r || out_ready || !in_last);
  assign acc      = in_valid && in_ready;
  assign coin_pop = acc && first;

  // Saturating sum and the coin compare.
  assign coin_cur = first ? coin_i.coin : coin_r;
  assign sum_add  = {1'b0, sum_r} + (SUM_W+1)'(in_prob);
  assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign hit_now  = !hit_r && (SUM_W'(coin_cur) < sum_sat);

  always_comb begin
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    coin_nxt      = coin_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    tok_nxt       = tok_r;
    fb_nxt        = fb_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (acc) begin
      if (in_last) begin
        // Close the vector and load the result.
        out_valid_nxt = 1'b1;
        tok_nxt       = IDX_OUT_W'(hit_r ? hit_idx_r : pos_r);
        fb_nxt        = !(hit_r || hit_now);
        pos_nxt       = '0;
        sum_nxt       = '0;
        hit_nxt       = 1'b0;
        hit_idx_nxt   = '0;
      end else begin
        sum_nxt  = sum_sat;
        coin_nxt = coin_cur;
        if (hit_now) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pos_r;
        end
        if (pos_r < LAST_POS) begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sum_r       <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      hit_r       <= hit_nxt;
      hit_idx_r   <= hit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and the held coin need no reset.
  always_ff @(posedge clk) begin
    coin_r <= coin_nxt;
    tok_r  <= tok_nxt;
    fb_r   <= fb_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_token_index = tok_r;
  assign out_fallback    = fb_r;

`ifndef SYNTHESIS
  a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
    first |-> (sum_r == '0) && !hit_r)
    else $error("vector state not cleared at vector start");
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> (hit_idx_r <= pos_r))
    else $error("hit index beyond current position");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(acc && in_last))
    else $error("pending result overwritten");
`endif

endmodule

@@ rtl/categorical_sampler_xorshift.sv @@
// Top level of the categorical sampler: APB seed register, coin generator, scan.
// Depends on csx_pkg, csx_coin_gen and csx_scan.
//
// Streams a probability vector in one unsigned Q1.24 element per transaction and
// returns one sampled index per vector, on the transaction marked last. The block
// takes one element per clock cycle, and vectors may follow each other with no
// gap, including vectors of a single element. The result appears the cycle after
// the last element is accepted and sits in an output register; non-last elements
// keep flowing while it waits, but a last element is held off until it is taken.
// Coins are drawn ahead: the xorshift64* state advances and its 64-bit product is
// formed from three 32x32 partial products over two pipeline stages into a
// four-entry coin queue. After reset or a seed write the first coin must pass both
// stages before it is queued; the first element of a vector is not accepted until
// a coin is there. The seed register sits at byte address 0; writing it reloads
// the generator and discards coins already drawn but not yet used.
module categorical_sampler_xorshift #(
  parameter int MAX_VOCAB = csx_pkg::MAX_VOCAB_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Probability stream.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [csx_pkg::PROB_W-1:0]     in_prob,
  input  logic                           in_last,
  // Sampled index.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [csx_pkg::IDX_OUT_W-1:0]  out_token_index,
  output logic                           out_fallback,
  // Configuration port.
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [csx_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [csx_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [csx_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import csx_pkg::*;

  logic [STATE_W-1:0] seed_r, seed_nxt;
  logic               cfg_wr;
  logic               seed_load;
  coin_t              coin;
  logic               coin_pop;

  // Register decode: bit 3 of the byte address selects the 64-bit slot.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign seed_load  = cfg_wr && (cfg_paddr[3] == REG_SEED);
  assign seed_nxt   = seed_load ? cfg_pwdata : seed_r;
  assign cfg_prdata = (cfg_paddr[3] == REG_SEED) ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  csx_coin_gen u_coin_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (seed_load),
    .load_value (cfg_pwdata),
    .pop        (coin_pop),
    .coin_o     (coin)
  );

  csx_scan #(
    .MAX_VOCAB (MAX_VOCAB)
  ) u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_prob         (in_prob),
    .in_last         (in_last),
    .coin_i          (coin),
    .coin_pop        (coin_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_index (out_token_index),
    .out_fallback    (out_fallback)
  );

endmodule
